// ===== hdl/elos_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package elos_pkg;

  localparam int DW   = 34;
  localparam int MA_W = 42;
  localparam int MB_W = 25;
  localparam int MP_W = MA_W + MB_W;
  localparam int TAB_LEN = 24;

  localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
  localparam logic [15:0] K_HI = 16'h9B74;
  localparam logic [15:0] K_LO = 16'hEDA8;

  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic       vec_mode;
    logic [4:0] idx;
  } cstep_t;

  function automatic logic [23:0] sat24(input logic signed [37:0] v);
    logic [23:0] r;
    if (v > 38'sd8388607) begin
      r = 24'h7FFFFF;
    end else if (v < -38'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/elliptical_orbit_stepper_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Elliptical orbit stepper.
// in_ channel: one request per tick (dt, centre, own position). out_ channel:
// one result per request (new position and spin angle).
// cfg_ port: APB-style writes of orbit_speed (0x0), spin_speed (0x4),
// minor_ratio (0x8); reads return the register.
// A request is taken only while the sequencer is idle. The time from accept
// to out_tvalid is set by the shared CORDIC shift-add unit stepping one
// iteration per cycle plus passes through the single shared multiplier. The
// first request after reset also runs the vectoring pass before the rotation.
// A new request is not taken until the previous one has written its result.
// A finished result sits in the output register; the next request may be
// accepted meanwhile, but it waits in its last step until the receiver takes
// the previous result.
// Reset (synchronous, rst_n low) restores the register defaults and clears
// the phases, radius and the started flag; the next request restarts.
module elliptical_orbit_stepper_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // dt, center_x, center_y, center_z, own_x, own_z
  input  wire logic [135:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pos_x, pos_y, pos_z, spin_angle
  output logic [87:0]       out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import elos_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_VINIT, S_VEC, S_VK1, S_VK2, S_VK3, S_PHO, S_PHS,
    S_RINIT, S_ROT, S_MC, S_MS, S_MT, S_MZ, S_FIN
  } state_t;

  localparam logic [1:0] REG_ORBIT = 2'd0;
  localparam logic [1:0] REG_SPIN  = 2'd1;
  localparam logic [1:0] REG_MINOR = 2'd2;

  state_t state_r;
  logic [20:0] orbit_speed_r, spin_speed_r;
  logic [15:0] minor_r;
  logic        started_r, neg_r, out_valid_r;
  logic [23:0] radius_r;
  logic [31:0] orbit_phase_r, spin_phase_r;
  logic [4:0]  cnt_r;
  logic signed [DW-1:0] x_r, y_r, z_r, xn, yn, zn;
  logic [15:0] dt_r;
  logic signed [23:0] cx_r, cy_r, cz_r, ox_r, oz_r;
  logic signed [36:0] offx_r, offz_r;
  logic signed [MP_W-1:0] p1_r, prod;
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic [87:0] out_data_r;
  cstep_t cs;

  logic signed [24:0] dx, dz;
  logic signed [DW-1:0] vx0, vz0, zs, cval, sval;
  logic [MP_W-1:0] acc;
  logic signed [MP_W-1:0] offx_full, offz_full;
  logic cfg_wr, last;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign last = (cnt_r == 5'(CORDIC_STEPS - 1));

  always_comb begin
    case (cfg_paddr[3:2])
      REG_ORBIT: cfg_prdata = {11'b0, orbit_speed_r};
      REG_SPIN:  cfg_prdata = {11'b0, spin_speed_r};
      REG_MINOR: cfg_prdata = {16'b0, minor_r};
      default:   cfg_prdata = 32'b0;
    endcase
  end

  assign cs.vec_mode = (state_r == S_VEC);
  assign cs.idx = cnt_r;

  elos_cordic_step u_step (
    .cs(cs), .x(x_r), .y(y_r), .z(z_r), .xn(xn), .yn(yn), .zn(zn)
  );

  assign cval = neg_r ? -x_r : x_r;
  assign sval = neg_r ? -y_r : y_r;

  always_comb begin
    case (state_r)
      S_VK1: begin ma = MA_W'(x_r); mb = MB_W'({1'b0, K_HI}); end
      S_VK2: begin ma = MA_W'(x_r); mb = MB_W'({1'b0, K_LO}); end
      S_PHO: begin
        ma = MA_W'({1'b0, dt_r});
        mb = MB_W'($signed(orbit_speed_r));
      end
      S_PHS: begin
        ma = MA_W'({1'b0, dt_r});
        mb = MB_W'($signed(spin_speed_r));
      end
      S_MC: begin ma = MA_W'(cval); mb = MB_W'({1'b0, radius_r}); end
      S_MS: begin ma = MA_W'(sval); mb = MB_W'({1'b0, radius_r}); end
      S_MT: begin
        ma = prod[MA_W+13:14];
        mb = MB_W'({1'b0, minor_r});
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  elos_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_r(prod));

  always_comb begin
    dx  = 25'(ox_r) - 25'(cx_r);
    dz  = 25'(oz_r) - 25'(cz_r);
    vx0 = DW'(dx) <<< 4;
    vz0 = DW'(dz) <<< 4;
    zs  = DW'($signed(orbit_phase_r));
    acc = MP_W'(p1_r <<< 16) + MP_W'(prod) + (MP_W'(1) << 35);
    offx_full = (prod + (MP_W'(1) <<< 29)) >>> 30;
    offz_full = (prod + (MP_W'(1) <<< 31)) >>> 32;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      orbit_speed_r <= 21'd10430;
      spin_speed_r  <= 21'd20861;
      minor_r       <= 16'd52429;
      started_r     <= 1'b0;
      radius_r      <= '0;
      orbit_phase_r <= '0;
      spin_phase_r  <= '0;
      out_valid_r   <= 1'b0;
      cnt_r         <= '0;
      neg_r         <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_ORBIT: orbit_speed_r <= cfg_pwdata[20:0];
          REG_SPIN:  spin_speed_r  <= cfg_pwdata[20:0];
          REG_MINOR: minor_r       <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            dt_r <= in_tdata[15:0];
            cx_r <= in_tdata[39:16];
            cy_r <= in_tdata[63:40];
            cz_r <= in_tdata[87:64];
            ox_r <= in_tdata[111:88];
            oz_r <= in_tdata[135:112];
            state_r <= started_r ? S_PHO : S_VINIT;
          end
        end
        S_VINIT: begin
          started_r <= 1'b1;
          cnt_r <= '0;
          if (dx == 25'sd0 && dz == 25'sd0) begin
            radius_r <= '0;
            orbit_phase_r <= '0;
            state_r <= S_PHO;
          end else begin
            if (dx < 0) begin
              x_r <= -vx0;
              y_r <= -vz0;
              z_r <= DW'(34'sh0_8000_0000);
            end else begin
              x_r <= vx0;
              y_r <= vz0;
              z_r <= '0;
            end
            state_r <= S_VEC;
          end
        end
        S_VEC: begin
          x_r <= xn;
          y_r <= yn;
          z_r <= zn;
          cnt_r <= cnt_r + 5'd1;
          if (last) state_r <= S_VK1;
        end
        S_VK1: state_r <= S_VK2;
        S_VK2: begin
          p1_r <= prod;
          state_r <= S_VK3;
        end
        S_VK3: begin
          radius_r <= (acc[MP_W-1:36] > (MP_W-36)'(24'hFFFFFF)) ? 24'hFFFFFF :
                      acc[59:36];
          orbit_phase_r <= z_r[31:0];
          state_r <= S_PHO;
        end
        S_PHO: state_r <= S_PHS;
        S_PHS: begin
          orbit_phase_r <= orbit_phase_r + prod[31:0];
          state_r <= S_RINIT;
        end
        S_RINIT: begin
          spin_phase_r <= spin_phase_r + prod[31:0];
          x_r <= DW'($signed({1'b0, INV_GAIN_Q30}));
          y_r <= '0;
          cnt_r <= '0;
          if (zs > DW'(34'sh0_4000_0000)) begin
            z_r <= zs - DW'(34'sh0_8000_0000);
            neg_r <= 1'b1;
          end else if (zs < -DW'(34'sh0_4000_0000)) begin
            z_r <= zs + DW'(34'sh0_8000_0000);
            neg_r <= 1'b1;
          end else begin
            z_r <= zs;
            neg_r <= 1'b0;
          end
          state_r <= S_ROT;
        end
        S_ROT: begin
          x_r <= xn;
          y_r <= yn;
          z_r <= zn;
          cnt_r <= cnt_r + 5'd1;
          if (last) state_r <= S_MC;
        end
        S_MC: state_r <= S_MS;
        S_MS: begin
          offx_r <= offx_full[36:0];
          state_r <= S_MT;
        end
        S_MT: state_r <= S_MZ;
        S_MZ: begin
          offz_r <= offz_full[36:0];
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_data_r <= {spin_phase_r[31:16],
                           sat24(38'(cz_r) + 38'(offz_r)),
                           cy_r,
                           sat24(38'(cx_r) + 38'(offx_r))};
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while busy");
  a_started_holds: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("started flag dropped");
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_FIN))
    else $error("result raised outside final step");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VEC || state_r == S_ROT) |-> (cnt_r < 5'(CORDIC_STEPS)))
    else $error("iteration count out of range");
`endif

endmodule
`default_nettype wire

// ===== hdl/elos_cordic_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
module elos_cordic_step (
  input  wire elos_pkg::cstep_t           cs,
  input  wire logic signed [elos_pkg::DW-1:0] x,
  input  wire logic signed [elos_pkg::DW-1:0] y,
  input  wire logic signed [elos_pkg::DW-1:0] z,
  output logic signed [elos_pkg::DW-1:0]      xn,
  output logic signed [elos_pkg::DW-1:0]      yn,
  output logic signed [elos_pkg::DW-1:0]      zn
);
  import elos_pkg::*;

  logic                 pos;
  logic signed [DW-1:0] xs, ys, a;

  always_comb begin
    pos = cs.vec_mode ? y[DW-1] : !z[DW-1];
    xs  = x >>> cs.idx;
    ys  = y >>> cs.idx;
    a   = $signed({{(DW-32){1'b0}}, ATAN_TAB[cs.idx]});
    if (pos) begin
      xn = x - ys;
      yn = y + xs;
      zn = z - a;
    end else begin
      xn = x + ys;
      yn = y - xs;
      zn = z + a;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/elos_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module elos_mul (
  input  wire logic                               clk,
  input  wire logic signed [elos_pkg::MA_W-1:0]   a,
  input  wire logic signed [elos_pkg::MB_W-1:0]   b,
  output logic signed [elos_pkg::MP_W-1:0]        p_r
);
  import elos_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule
`default_nettype wire

// ===== test/elliptical_orbit_stepper_unit_tb.sv =====
`timescale 1ns / 1ps
module elliptical_orbit_stepper_unit_tb;
  import elos_pkg::*;

  localparam int STEPS = 16;
  localparam logic [3:0] ADDR_ORBIT_SPEED = 4'h0;
  localparam logic [3:0] ADDR_SPIN_SPEED  = 4'h4;
  localparam logic [3:0] ADDR_MINOR_RATIO = 4'h8;

  typedef struct packed {
    logic [23:0] own_z;
    logic [23:0] own_x;
    logic [23:0] center_z;
    logic [23:0] center_y;
    logic [23:0] center_x;
    logic [15:0] dt;
  } tick_t;

  typedef struct packed {
    logic [15:0] spin_angle;
    logic [23:0] pos_z;
    logic [23:0] pos_y;
    logic [23:0] pos_x;
  } orbit_pos_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [135:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  elliptical_orbit_stepper_unit #(.CORDIC_STEPS(STEPS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10 clk = ~clk;

  // predictor state
  logic signed [20:0] orbit_speed_m, spin_speed_m;
  logic [15:0] minor_ratio_m;
  logic started_m;
  logic [23:0] radius_m;
  logic [31:0] orbit_phase_m, spin_phase_m;

  orbit_pos_t expected_pos_q[$];
  int errors = 0;
  bit rx_quiet = 1'b0;
  bit hold_rx = 1'b0;
  bit rx_hold_done = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic longint shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic logic [23:0] clamp24(input longint v);
    if (v > 64'sd8388607) return 24'h7FFFFF;
    if (v < -64'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

  function automatic void find_start(input longint dx, input longint dz);
    longint x, y, z, nx;
    longint unsigned r;
    x = dx * 16; y = dz * 16; z = 0;
    if (dx == 0 && dz == 0) begin
      radius_m = '0; orbit_phase_m = '0;
      return;
    end
    if (x < 0) begin
      x = -x; y = -y; z = 64'sh80000000;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + shr(y, i); y = y - shr(x, i); z += longint'(ATAN_TAB[i]);
      end else begin
        nx = x - shr(y, i); y = y + shr(x, i); z -= longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    r = (longint'(x) * 64'd2608131496 + (64'd1 << 35)) >> 36;
    radius_m = (r > 64'hFFFFFF) ? 24'hFFFFFF : r[23:0];
    orbit_phase_m = z[31:0];
  endfunction

  function automatic orbit_pos_t advance_orbit(input tick_t t);
    longint cx, cy, cz, x, y, z, nx, offx, offz, tt, dt;
    bit neg;
    orbit_pos_t p;
    cx = longint'(signed'(t.center_x));
    cy = longint'(signed'(t.center_y));
    cz = longint'(signed'(t.center_z));
    dt = longint'(t.dt);
    if (!started_m) begin
      find_start(longint'(signed'(t.own_x)) - cx, longint'(signed'(t.own_z)) - cz);
      started_m = 1'b1;
    end
    orbit_phase_m += 32'(dt * longint'(orbit_speed_m));
    spin_phase_m += 32'(dt * longint'(spin_speed_m));
    z = longint'(signed'(orbit_phase_m));
    x = 652032874; y = 0; neg = 1'b0;
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000; neg = 1'b1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000; neg = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - shr(y, i); y = y + shr(x, i); z -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + shr(y, i); y = y - shr(x, i); z += longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    if (neg) begin
      x = -x; y = -y;
    end
    offx = shr(x * longint'(radius_m) + (64'sd1 <<< 29), 30);
    tt = shr(y * longint'(radius_m), 14);
    offz = shr(tt * longint'(minor_ratio_m) + (64'sd1 <<< 31), 32);
    p.pos_x = clamp24(cx + offx);
    p.pos_y = t.center_y;
    p.pos_z = clamp24(cz + offz);
    p.spin_angle = spin_phase_m[31:16];
    return p;
  endfunction

  task automatic send_tick(input tick_t t, input bit gaps);
    int g;
    if (gaps && $urandom_range(0, 3) == 0) begin
      g = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_pos_q.push_back(advance_orbit(t));
  endtask

  task automatic idle_sender();
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    idle_sender();
    guard = 0;
    while (expected_pos_q.size() != 0 && guard < 20000) begin
      @(posedge clk); guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [3:0] addr, input logic [31:0] val);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= addr; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (addr)
      ADDR_ORBIT_SPEED: orbit_speed_m = val[20:0];
      ADDR_SPIN_SPEED:  spin_speed_m = val[20:0];
      ADDR_MINOR_RATIO: minor_ratio_m = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [23:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 4000)) - 24'd2000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.dt = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
    t.center_x = rand_pos(); t.center_y = rand_pos(); t.center_z = rand_pos();
    t.own_x = rand_pos(); t.own_z = rand_pos();
    return t;
  endfunction

  // result checker
  always @(posedge clk) begin
    orbit_pos_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_pos_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(got.pos_x), 32'h0);
      end else begin
        want = expected_pos_q.pop_front();
        if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
        if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
        if (got.pos_z !== want.pos_z) report_mismatch("pos_z", got.pos_z, want.pos_z);
        if (got.spin_angle !== want.spin_angle)
          report_mismatch("spin_angle", got.spin_angle, want.spin_angle);
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n || hold_rx) begin
      out_tready <= 1'b0;
    end else if (rx_quiet) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin : long_rx_hold
    wait (hold_rx);
    repeat (400) @(posedge clk);
    hold_rx = 1'b0;
    rx_hold_done = 1'b1;
  end

  task automatic restart_orbit(input tick_t t);
    // started flag only clears with reset; first tick seeds the radius
    send_tick(t, 1'b0);
  endtask

  task automatic test_directed();
    tick_t t;
    t = '0; t.dt = 16'd1000; t.own_x = 24'd2560;
    restart_orbit(t);
    t.dt = 16'h0000; send_tick(t, 1'b0);
    t.dt = 16'hFFFF; send_tick(t, 1'b0);
    t.center_x = 24'h7FFFFF; t.center_z = 24'h7FFFFF; t.center_y = 24'h800000;
    send_tick(t, 1'b0);
    t.center_x = 24'h800000; t.center_z = 24'h800000; t.center_y = 24'h7FFFFF;
    send_tick(t, 1'b0);
    for (int i = 0; i < 8; i++) begin
      t = '0; t.dt = 16'(16384 + i * 4096); send_tick(t, 1'b0);
    end
    wait_drained();
  endtask

  task automatic test_config_sweep();
    tick_t t;
    logic [31:0] os [5] = '{32'h100000, 32'h0FFFFF, 32'h0, 32'h1FFFFF, 32'd5000};
    logic [31:0] ss [5] = '{32'h0FFFFF, 32'h100000, 32'h1, 32'h0, 32'd777};
    logic [31:0] mr [5] = '{32'h0, 32'hFFFF, 32'h8000, 32'h1, 32'd52429};
    for (int k = 0; k < 5; k++) begin
      cfg_write(ADDR_ORBIT_SPEED, os[k]);
      cfg_write(ADDR_SPIN_SPEED, ss[k]);
      cfg_write(ADDR_MINOR_RATIO, mr[k]);
      for (int i = 0; i < 40; i++) send_tick(rand_tick(), 1'b1);
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    for (int i = 0; i < 10; i++) send_tick(rand_tick(), 1'b0);
    idle_sender();
    wait (rx_hold_done);
    wait_drained();
  endtask

  task automatic test_random();
    for (int i = 0; i < 1100; i++) begin
      if (i % 150 == 149) begin
        wait_drained();
        cfg_write(ADDR_ORBIT_SPEED, $urandom);
        cfg_write(ADDR_SPIN_SPEED, $urandom);
        cfg_write(ADDR_MINOR_RATIO, $urandom);
      end
      send_tick(rand_tick(), 1'b1);
    end
    wait_drained();
  endtask

  task automatic test_full_rate();
    rx_quiet = 1'b1;
    for (int i = 0; i < 200; i++) send_tick(rand_tick(), 1'b0);
    wait_drained();
  endtask

  initial begin
    orbit_speed_m = 21'sd10430; spin_speed_m = 21'sd20861; minor_ratio_m = 16'd52429;
    started_m = 1'b0; radius_m = '0; orbit_phase_m = '0; spin_phase_m = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    test_full_rate();
    if (errors == 0 && expected_pos_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== elliptical_orbit_stepper_unit.f =====
hdl/elos_pkg.sv
hdl/elos_cordic_step.sv
hdl/elos_mul.sv
hdl/elliptical_orbit_stepper_unit.sv
test/elliptical_orbit_stepper_unit_tb.sv
